// ===== src/ble_frag_pkg.sv =====
// Shared types and constants for the link fragment reassembler.
// No dependencies; imported by every module under src.
package ble_frag_pkg;

    // Payload buffer size in bytes; the accepted length never exceeds it.
    localparam int unsigned BUFFER_BYTES = 1024;

    localparam int unsigned LEN_W   = 16;
    localparam int unsigned CNT_W   = 11;
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;

    localparam logic [7:0]       INIT_COMMAND_RESET = 8'h83;
    localparam logic [CNT_W-1:0] MAX_LENGTH_RESET   = CNT_W'(1024);
    localparam logic [LEN_W-1:0] BUFFER_LIMIT       = LEN_W'(BUFFER_BYTES);

    // Register indexes of the configuration port
    localparam logic REG_INIT_COMMAND = 1'b0;
    localparam logic REG_MAX_LENGTH   = 1'b1;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_SEQ   = 3'd1,
        ERR_STRAY     = 3'd2,
        ERR_OVERFLOW  = 3'd3,
        ERR_SHORT_HDR = 3'd4
    } err_code_t;

    typedef enum logic [1:0] {
        HDR_IDLE   = 2'd0,
        HDR_LEN_HI = 2'd1,
        HDR_LEN_LO = 2'd2
    } hdr_pos_t;

    typedef struct packed {
        logic [7:0]       init_command;
        logic [CNT_W-1:0] max_message_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frag_start;
        logic       frag_end;
    } frag_item_t;

    typedef struct packed {
        logic             data_valid;
        logic [7:0]       payload_byte;
        logic [IDX_W-1:0] byte_index;
        logic             message_done;
        logic [LEN_W-1:0] message_length;
        err_code_t        error_code;
    } frag_result_t;

endpackage

// ===== src/ble_frag_cfg.sv =====
// APB-style configuration registers: init command byte and length limit.
// Depends on ble_frag_pkg.
module ble_frag_cfg
    import ble_frag_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [7:0]       init_command_reg;
    logic [CNT_W-1:0] max_length_reg;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_command_reg <= INIT_COMMAND_RESET;
            max_length_reg   <= MAX_LENGTH_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_INIT_COMMAND: init_command_reg <= pwdata[7:0];
                REG_MAX_LENGTH:   max_length_reg   <= pwdata[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_INIT_COMMAND: prdata = {(DATA_W-8)'(0), init_command_reg};
            REG_MAX_LENGTH:   prdata = {(DATA_W-CNT_W)'(0), max_length_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.init_command       = init_command_reg;
    assign cfg.max_message_length = max_length_reg;

endmodule

// ===== src/ble_frag_in_stage.sv =====
// Input register stage: captures one fragment byte per cycle unless the held item is stalled.
// Depends on ble_frag_pkg.
module ble_frag_in_stage
    import ble_frag_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  frag_item_t in_item,
    output logic       stage_valid,
    input  logic       stage_take,
    output frag_item_t stage_item
);

    logic       valid_reg;
    frag_item_t item_reg;

    // Refill whenever the stage is empty or the held item moves on in the same cycle
    assign in_ready    = !valid_reg || stage_take;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== src/ble_frag_engine.sv =====
// Depends on ble_frag_pkg. Reassembly state and result register: header parse,
// sequence check, payload counting, completion; one byte per cycle unless stalled.
module ble_frag_engine
    import ble_frag_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         item_valid,
    output logic         item_take,
    input  frag_item_t   item,
    output logic         out_valid,
    input  logic         out_ready,
    output frag_result_t result
);

    logic             in_msg_reg,   in_msg_next;
    logic [LEN_W-1:0] decl_len_reg, decl_len_next;
    logic [CNT_W-1:0] rcnt_reg,     rcnt_next;
    logic [7:0]       seq_reg,      seq_next;
    hdr_pos_t         hpos_reg,     hpos_next;
    logic [7:0]       len_hi_reg,   len_hi_next;
    logic             ignore_reg,   ignore_next;
    logic             out_valid_reg;
    frag_result_t     result_reg,   result_next;

    logic             opens;
    logic [LEN_W-1:0] limit;
    logic [LEN_W-1:0] max_len_ext;
    logic [LEN_W-1:0] new_len;

    assign item_take = item_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    assign max_len_ext = {(LEN_W-CNT_W)'(0), cfg.max_message_length};
    assign limit       = (max_len_ext < BUFFER_LIMIT) ? max_len_ext : BUFFER_LIMIT;
    assign new_len     = {len_hi_reg, item.data_byte};

    always_comb
    begin
        in_msg_next   = in_msg_reg;
        decl_len_next = decl_len_reg;
        rcnt_next     = rcnt_reg;
        seq_next      = seq_reg;
        hpos_next     = hpos_reg;
        len_hi_next   = len_hi_reg;
        ignore_next   = ignore_reg;
        opens         = 1'b0;
        result_next   = '0;
        result_next.error_code = ERR_NONE;

        if (item.frag_start)
        begin
            ignore_next = 1'b0;
            hpos_next   = HDR_IDLE;
            if (in_msg_reg)
            begin
                if (item.data_byte == seq_reg)
                begin
                    seq_next = seq_reg + 8'd1;
                end
                else
                begin
                    // Lost fragment: drop the message, maybe restart here
                    in_msg_next            = 1'b0;
                    result_next.error_code = ERR_BAD_SEQ;
                    opens                  = (item.data_byte == cfg.init_command);
                    ignore_next            = !opens;
                end
            end
            else
            begin
                opens = (item.data_byte == cfg.init_command);
                if (!opens)
                begin
                    result_next.error_code = ERR_STRAY;
                    ignore_next            = 1'b1;
                end
            end
            if (opens)
            begin
                hpos_next = HDR_LEN_HI;
            end
        end
        else if (ignore_reg)
        begin
            // skip rest of an ignored fragment
        end
        else if (hpos_reg == HDR_LEN_HI)
        begin
            len_hi_next = item.data_byte;
            hpos_next   = HDR_LEN_LO;
        end
        else if (hpos_reg == HDR_LEN_LO)
        begin
            hpos_next     = HDR_IDLE;
            decl_len_next = new_len;
            rcnt_next     = '0;
            seq_next      = '0;
            if (new_len > limit)
            begin
                result_next.error_code = ERR_OVERFLOW;
                in_msg_next            = 1'b0;
                ignore_next            = 1'b1;
            end
            else
            begin
                in_msg_next = 1'b1;
            end
        end
        else if (in_msg_reg)
        begin
            if ({(LEN_W-CNT_W)'(0), rcnt_reg} < decl_len_reg)
            begin
                result_next.data_valid   = 1'b1;
                result_next.payload_byte = item.data_byte;
                result_next.byte_index   = rcnt_reg[IDX_W-1:0];
                rcnt_next                = rcnt_reg + CNT_W'(1);
            end
        end

        if (item.frag_end)
        begin
            if (hpos_next != HDR_IDLE)
            begin
                if (result_next.error_code == ERR_NONE)
                begin
                    result_next.error_code = ERR_SHORT_HDR;
                end
                hpos_next = HDR_IDLE;
            end
            else if (in_msg_next && ({(LEN_W-CNT_W)'(0), rcnt_next} >= decl_len_next))
            begin
                result_next.message_done = 1'b1;
                in_msg_next              = 1'b0;
            end
            ignore_next = 1'b0;
        end

        result_next.message_length = decl_len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg    <= 1'b0;
            decl_len_reg  <= '0;
            rcnt_reg      <= '0;
            seq_reg       <= '0;
            hpos_reg      <= HDR_IDLE;
            len_hi_reg    <= '0;
            ignore_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                in_msg_reg   <= in_msg_next;
                decl_len_reg <= decl_len_next;
                rcnt_reg     <= rcnt_next;
                seq_reg      <= seq_next;
                hpos_reg     <= hpos_next;
                len_hi_reg   <= len_hi_next;
                ignore_reg   <= ignore_next;
            end
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== src/ble_fragment_reassembler.sv =====
// Reassembles framed messages from received link fragments, one byte per item.
// An item passes an input register and then the reassembly logic into a result
// register, so one item is taken every cycle while the output side does not
// stall; each result is held at the outputs until the output side takes it.
// Every item gives exactly one result. Configuration (init command at byte 0,
// length limit at byte 4) is to be written through the APB port by the user
// while the block is idle; the block itself does not enforce this.
module ble_fragment_reassembler
    import ble_frag_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              frag_start,
    input  logic              frag_end,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              data_valid,
    output logic [7:0]        payload_byte,
    output logic [IDX_W-1:0]  byte_index,
    output logic              message_done,
    output logic [LEN_W-1:0]  message_length,
    output logic [2:0]        error_code
);

    cfg_t         cfg;
    frag_item_t   in_item;
    frag_item_t   stage_item;
    logic         stage_valid;
    logic         stage_take;
    frag_result_t result;

    assign in_item.data_byte  = data_byte;
    assign in_item.frag_start = frag_start;
    assign in_item.frag_end   = frag_end;

    ble_frag_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ble_frag_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .stage_valid (stage_valid),
        .stage_take  (stage_take),
        .stage_item  (stage_item)
    );

    ble_frag_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (stage_valid),
        .item_take  (stage_take),
        .item       (stage_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    assign data_valid     = result.data_valid;
    assign payload_byte   = result.payload_byte;
    assign byte_index     = result.byte_index;
    assign message_done   = result.message_done;
    assign message_length = result.message_length;
    assign error_code     = result.error_code;

    // A completed message never carries an error
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && message_done) |-> (error_code == ERR_NONE))
        else $error("message_done with error code set");

    // Payload bytes are only produced error-free
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && data_valid) |-> (error_code == ERR_NONE))
        else $error("payload byte with error code set");

    // A payload byte always lies inside the declared length
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && data_valid) |->
            ({(LEN_W-IDX_W)'(0), byte_index} < message_length))
        else $error("byte_index beyond declared length");

    // A stalled result is held by the engine
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(result)))
        else $error("result changed while stalled");

endmodule
